// ----- rtl/core/i4gq_pkg.sv -----
// ----------------------------------------------------------------------------
// i4gq_pkg
// Shared types and constants of the 4-bit group-quantized dot product core.
// ----------------------------------------------------------------------------
package i4gq_pkg;

    // Lane structure of one weight word.
    localparam int LANES     = 8;
    localparam int CODE_BITS = 4;
    localparam int ACT_W     = 16;
    localparam int COEF_W    = 16;

    // Datapath widths. A lane product is 16 x 4 bits and fits in 20 signed bits.
    localparam int PROD_W = ACT_W + CODE_BITS;
    localparam int DOT_W  = PROD_W + 3;
    localparam int ASUM_W = ACT_W + 3;
    localparam int GDOT_W = 28;
    localparam int GSUM_W = 24;
    localparam int PDOT_W = COEF_W + GDOT_W;
    localparam int PSUM_W = COEF_W + GSUM_W;
    localparam int CTRB_W = PDOT_W + 1;
    localparam int ACC_W  = 48;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Boundary codes. The reserved code behaves like an output end.
    localparam logic [1:0] BND_INNER      = 2'd0;
    localparam logic [1:0] BND_GROUP_END  = 2'd1;
    localparam logic [1:0] BND_OUTPUT_END = 2'd2;
    localparam logic [1:0] BND_RESERVED   = 2'd3;

    typedef struct packed {
        logic        [31:0] weight_word;
        logic signed [15:0] act_0;
        logic signed [15:0] act_1;
        logic signed [15:0] act_2;
        logic signed [15:0] act_3;
        logic signed [15:0] act_4;
        logic signed [15:0] act_5;
        logic signed [15:0] act_6;
        logic signed [15:0] act_7;
        logic signed [15:0] group_scale;
        logic signed [15:0] group_bias;
        logic        [1:0]  boundary;
    } item_t;

    typedef struct packed {
        logic signed [47:0] dot_result;
        logic               saturated;
    } result_t;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic signed [DOT_W-1:0]  dot;
        logic signed [ASUM_W-1:0] act_sum;
        logic signed [COEF_W-1:0] scale;
        logic signed [COEF_W-1:0] bias;
        logic                     group_end;
        logic                     output_end;
    } q_entry_t;

endpackage

// ----- rtl/core/int4_group_quant_dot_product_core.sv -----
// ----------------------------------------------------------------------------
// int4_group_quant_dot_product_core
// Streaming dot product of 4-bit group-quantized weights with Q8.8 activations.
// ----------------------------------------------------------------------------
// Usage: the item channel (item_valid, item_ready, item) carries one transaction
// per weight word: eight unsigned 4-bit codes, the eight paired activations, the
// group's scale and bias, and a boundary code (inside group, group end, or
// output end). The result channel (result_valid, result_ready, result) carries
// one transaction per output end: the 48-bit value with 20 fraction bits and a
// sticky flag that is set if any accumulator clipped during that output.
// Throughput is one item per cycle while item_ready stays high. The front
// registers the lane products and reduces them into a four-entry queue; the
// back accumulates the group, folds it through two 16 x 28 and 16 x 24
// multipliers, and updates the output accumulator, each in a stage of its
// own. The item that ends an output passes the front register, the queue, the
// operand, product and contribution stages and then the result register.
// When the receiver stalls, the result register holds; the back keeps
// taking words until another output end needs that register, then the queue
// fills and item_ready drops. Reset clears all accumulators and empties the
// queue and pipeline; no result is pending after reset.
// ----------------------------------------------------------------------------
module int4_group_quant_dot_product_core
    import i4gq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic     push_valid;
    logic     push_ready;
    q_entry_t push_entry;
    logic     pop_valid;
    logic     pop_ready;
    q_entry_t pop_entry;

    // Lane products, lane reduction and boundary classification.
    i4gq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decouples the front from stalls of the fold and result stages.
    i4gq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Group and output accumulation with saturation.
    i4gq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- rtl/core/i4gq_front.sv -----
// ----------------------------------------------------------------------------
// i4gq_front
// Accepts items, forms the eight lane products and classifies the boundary,
// then hands the word's dot product and activation sum to the queue.
// ----------------------------------------------------------------------------
module i4gq_front
    import i4gq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  item_t    item,
    output logic     push_valid,
    input  logic     push_ready,
    output q_entry_t push_entry
);

    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [LANES];
    logic signed [ACT_W-1:0]  s1_act_reg  [LANES];
    logic signed [COEF_W-1:0] s1_scale_reg;
    logic signed [COEF_W-1:0] s1_bias_reg;
    logic                     s1_group_end_reg;
    logic                     s1_output_end_reg;

    logic signed [ACT_W-1:0]  act_lane [LANES];
    logic signed [PROD_W-1:0] s1_prod_next [LANES];
    logic                     take;

    assign act_lane[0] = item.act_0;
    assign act_lane[1] = item.act_1;
    assign act_lane[2] = item.act_2;
    assign act_lane[3] = item.act_3;
    assign act_lane[4] = item.act_4;
    assign act_lane[5] = item.act_5;
    assign act_lane[6] = item.act_6;
    assign act_lane[7] = item.act_7;

    assign item_ready = !s1_valid_reg || push_ready;
    assign take       = item_valid && item_ready;

    // Signed activation times unsigned code, one small multiplier per lane.
    always_comb
    begin
        logic signed [PROD_W:0] full [LANES];
        for (int i = 0; i < LANES; i++)
        begin
            full[i] = act_lane[i] * $signed({1'b0, item.weight_word[CODE_BITS*i +: CODE_BITS]});
            s1_prod_next[i] = full[i][PROD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                s1_prod_reg[i] <= s1_prod_next[i];
                s1_act_reg[i]  <= act_lane[i];
            end
            s1_scale_reg      <= item.group_scale;
            s1_bias_reg       <= item.group_bias;
            s1_group_end_reg  <= (item.boundary != BND_INNER);
            s1_output_end_reg <= (item.boundary == BND_OUTPUT_END) ||
                                 (item.boundary == BND_RESERVED);
        end
    end

    // Reduce the lanes of the registered word into the queue entry.
    always_comb
    begin
        logic [DOT_W-1:0]  dot_acc;
        logic [ASUM_W-1:0] sum_acc;
        dot_acc = '0;
        sum_acc = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dot_acc = dot_acc + {{(DOT_W-PROD_W){s1_prod_reg[i][PROD_W-1]}}, s1_prod_reg[i]};
            sum_acc = sum_acc + {{(ASUM_W-ACT_W){s1_act_reg[i][ACT_W-1]}}, s1_act_reg[i]};
        end
        push_entry.dot        = dot_acc;
        push_entry.act_sum    = sum_acc;
        push_entry.scale      = s1_scale_reg;
        push_entry.bias       = s1_bias_reg;
        push_entry.group_end  = s1_group_end_reg;
        push_entry.output_end = s1_output_end_reg;
    end

    assign push_valid = s1_valid_reg;

endmodule

// ----- rtl/core/i4gq_queue.sv -----
// ----------------------------------------------------------------------------
// i4gq_queue
// Short first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module i4gq_queue
    import i4gq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_entry
);

    q_entry_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/i4gq_back.sv -----
// ----------------------------------------------------------------------------
// i4gq_back
// Group accumulation, group fold (scale and bias products) and the saturating
// output accumulator, with the result register at the end.
// ----------------------------------------------------------------------------
module i4gq_back
    import i4gq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pop_valid,
    output logic     pop_ready,
    input  q_entry_t pop_entry,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  result
);

    localparam logic signed [GDOT_W-1:0] GDOT_MAX = {1'b0, {(GDOT_W-1){1'b1}}};
    localparam logic signed [GDOT_W-1:0] GDOT_MIN = {1'b1, {(GDOT_W-1){1'b0}}};
    localparam logic signed [GSUM_W-1:0] GSUM_MAX = {1'b0, {(GSUM_W-1){1'b1}}};
    localparam logic signed [GSUM_W-1:0] GSUM_MIN = {1'b1, {(GSUM_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

    // Group accumulators.
    logic signed [GDOT_W-1:0] gdot_reg;
    logic signed [GSUM_W-1:0] gsum_reg;
    logic                     gclip_reg;

    // Operand stage of the fold.
    logic                     m_valid_reg;
    logic signed [GDOT_W-1:0] m_gdot_reg;
    logic signed [GSUM_W-1:0] m_gsum_reg;
    logic signed [COEF_W-1:0] m_scale_reg;
    logic signed [COEF_W-1:0] m_bias_reg;
    logic                     m_output_end_reg;
    logic                     m_clip_reg;

    // Product stage.
    logic                     p_valid_reg;
    logic signed [PDOT_W-1:0] p_dot_reg;
    logic signed [PSUM_W-1:0] p_sum_reg;
    logic                     p_output_end_reg;
    logic                     p_clip_reg;

    // Contribution stage.
    logic                     c_valid_reg;
    logic signed [CTRB_W-1:0] c_contrib_reg;
    logic                     c_output_end_reg;
    logic                     c_clip_reg;

    // Output accumulator and result register.
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     aclip_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic                     m_ready;
    logic                     p_ready;
    logic                     c_ready;
    logic                     a_take;
    logic                     g_take;

    logic [GDOT_W:0]          gdot_sum;
    logic [GSUM_W:0]          gsum_sum;
    logic signed [GDOT_W-1:0] gdot_next;
    logic signed [GSUM_W-1:0] gsum_next;
    logic                     gclip_next;
    logic signed [PDOT_W-1:0] p_dot_next;
    logic signed [PSUM_W-1:0] p_sum_next;
    logic [CTRB_W-1:0]        c_contrib_next;
    logic [ACC_W:0]           acc_sum;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     aclip_next;

    // Stage readiness, back to front.
    assign a_take  = c_valid_reg && (!c_output_end_reg || !out_valid_reg || result_ready);
    assign c_ready = !c_valid_reg || a_take;
    assign p_ready = !p_valid_reg || c_ready;
    assign m_ready = !m_valid_reg || p_ready;

    // A word inside a group only updates the group state; a group end also
    // needs room in the fold pipeline.
    assign pop_ready = !pop_entry.group_end || m_ready;
    assign g_take    = pop_valid && pop_ready;

    always_comb
    begin
        gdot_sum = {gdot_reg[GDOT_W-1], gdot_reg} +
                   {{(GDOT_W+1-DOT_W){pop_entry.dot[DOT_W-1]}}, pop_entry.dot};
        gsum_sum = {gsum_reg[GSUM_W-1], gsum_reg} +
                   {{(GSUM_W+1-ASUM_W){pop_entry.act_sum[ASUM_W-1]}}, pop_entry.act_sum};
        gclip_next = gclip_reg;
        if (gdot_sum[GDOT_W] != gdot_sum[GDOT_W-1])
        begin
            gdot_next  = gdot_sum[GDOT_W] ? GDOT_MIN : GDOT_MAX;
            gclip_next = 1'b1;
        end
        else
        begin
            gdot_next = gdot_sum[GDOT_W-1:0];
        end
        if (gsum_sum[GSUM_W] != gsum_sum[GSUM_W-1])
        begin
            gsum_next  = gsum_sum[GSUM_W] ? GSUM_MIN : GSUM_MAX;
            gclip_next = 1'b1;
        end
        else
        begin
            gsum_next = gsum_sum[GSUM_W-1:0];
        end
    end

    assign p_dot_next = m_scale_reg * m_gdot_reg;
    assign p_sum_next = m_bias_reg * m_gsum_reg;

    assign c_contrib_next = {p_dot_reg[PDOT_W-1], p_dot_reg} +
                            {{(CTRB_W-PSUM_W){p_sum_reg[PSUM_W-1]}}, p_sum_reg};

    always_comb
    begin
        acc_sum = {acc_reg[ACC_W-1], acc_reg} +
                  {{(ACC_W+1-CTRB_W){c_contrib_reg[CTRB_W-1]}}, c_contrib_reg};
        aclip_next = aclip_reg || c_clip_reg;
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_next   = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
            aclip_next = 1'b1;
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gdot_reg      <= '0;
            gsum_reg      <= '0;
            gclip_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            acc_reg       <= '0;
            aclip_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (g_take)
            begin
                if (pop_entry.group_end)
                begin
                    gdot_reg  <= '0;
                    gsum_reg  <= '0;
                    gclip_reg <= 1'b0;
                end
                else
                begin
                    gdot_reg  <= gdot_next;
                    gsum_reg  <= gsum_next;
                    gclip_reg <= gclip_next;
                end
            end
            if (m_ready)
            begin
                m_valid_reg <= g_take && pop_entry.group_end;
            end
            if (p_ready)
            begin
                p_valid_reg <= m_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= p_valid_reg;
            end
            if (a_take)
            begin
                if (c_output_end_reg)
                begin
                    acc_reg   <= '0;
                    aclip_reg <= 1'b0;
                end
                else
                begin
                    acc_reg   <= acc_next;
                    aclip_reg <= aclip_next;
                end
            end
            if (a_take && c_output_end_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_take && pop_entry.group_end && m_ready)
        begin
            m_gdot_reg       <= gdot_next;
            m_gsum_reg       <= gsum_next;
            m_scale_reg      <= pop_entry.scale;
            m_bias_reg       <= pop_entry.bias;
            m_output_end_reg <= pop_entry.output_end;
            m_clip_reg       <= gclip_next;
        end
        if (p_ready && m_valid_reg)
        begin
            p_dot_reg        <= p_dot_next;
            p_sum_reg        <= p_sum_next;
            p_output_end_reg <= m_output_end_reg;
            p_clip_reg       <= m_clip_reg;
        end
        if (c_ready && p_valid_reg)
        begin
            c_contrib_reg    <= c_contrib_next;
            c_output_end_reg <= p_output_end_reg;
            c_clip_reg       <= p_clip_reg;
        end
        if (a_take && c_output_end_reg)
        begin
            out_reg.dot_result <= acc_next;
            out_reg.saturated  <= aclip_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4-bit group-quantized dot product core.
// ----------------------------------------------------------------------------
// Weight words are streamed through the item channel as whole outputs: groups
// of words that close with a group end, and a final word that closes the
// output. A behavioral model of the datapath runs on every accepted item
// transaction and queues the value and clip flag that the next result
// transaction must carry. Results are compared field by field in order.
// Stimulus runs in three phases: hand-picked corner words, long saturating
// sequences, and randomly shaped outputs with random content. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import i4gq_pkg::*;

    localparam int RANDOM_ITEMS = 565;
    localparam int MAX_GAP      = 8;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;

    // Extremes of a Q8.8 activation or a Q4.12 coefficient.
    localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;

    // Saturation bounds of the group and output accumulators.
    localparam longint GDOT_MAX = (longint'(1) <<< (GDOT_W - 1)) - 1;
    localparam longint GDOT_MIN = -(longint'(1) <<< (GDOT_W - 1));
    localparam longint GSUM_MAX = (longint'(1) <<< (GSUM_W - 1)) - 1;
    localparam longint GSUM_MIN = -(longint'(1) <<< (GSUM_W - 1));
    localparam longint ACC_MAX  = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN  = -(longint'(1) <<< (ACC_W - 1));

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Words waiting to be driven, and results the model says must come back.
    item_t   pending_items[$];
    result_t expected_outputs[$];

    // Model copy of the accumulators.
    longint  model_gdot = 0;
    longint  model_gsum = 0;
    longint  model_acc  = 0;
    bit      model_clip = 1'b0;

    // Handshake bookkeeping shared between the edge-sampled monitor and the
    // falling-edge drivers.
    bit      item_fired   = 1'b0;
    bit      send_burst   = 1'b0;
    int      send_gap     = 0;
    bit      stall_armed  = 1'b0;
    bit      recv_burst   = 1'b0;
    int      recv_stall   = 0;
    int      idle_cycles  = 0;
    int      mismatches   = 0;
    int      words_queued = 0;

    int4_group_quant_dot_product_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Datapath model
    // ------------------------------------------------------------------

    // Clamps a running sum to its register width; any clip marks the output.
    function automatic longint saturate(longint v, longint lo, longint hi);
        if (v > hi)
        begin
            model_clip = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            model_clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Folds one accepted word into the model. The word is always added to the
    // group sums first; a group end then scales the group into the output
    // accumulator, and an output end (the reserved code counts as one)
    // queues the finished value and clears everything for the next output.
    task automatic accumulate_word(item_t it);
        logic signed [15:0] acts [LANES];
        longint word_dot;
        longint word_sum;
        longint contrib;
        result_t res;
        acts = '{it.act_0, it.act_1, it.act_2, it.act_3,
                 it.act_4, it.act_5, it.act_6, it.act_7};
        word_dot = 0;
        word_sum = 0;
        for (int i = 0; i < LANES; i++)
        begin
            // Codes are unsigned nibbles, activations are signed.
            word_dot += longint'(acts[i])
                        * longint'(it.weight_word[CODE_BITS*i +: CODE_BITS]);
            word_sum += longint'(acts[i]);
        end
        model_gdot = saturate(model_gdot + word_dot, GDOT_MIN, GDOT_MAX);
        model_gsum = saturate(model_gsum + word_sum, GSUM_MIN, GSUM_MAX);

        if (it.boundary != BND_INNER)
        begin
            // Q.8 times Q4.12 lands exactly on 20 fraction bits.
            contrib = longint'(it.group_scale) * model_gdot
                      + longint'(it.group_bias) * model_gsum;
            model_acc  = saturate(model_acc + contrib, ACC_MIN, ACC_MAX);
            model_gdot = 0;
            model_gsum = 0;
            if (it.boundary == BND_OUTPUT_END || it.boundary == BND_RESERVED)
            begin
                res.dot_result = model_acc[ACC_W-1:0];
                res.saturated  = model_clip;
                expected_outputs.push_back(res);
                model_acc  = 0;
                model_clip = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge, checks results
    // against the oldest expectation, runs the model on accepted items, and
    // keeps the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_valid && result_ready)
            begin
                moved       = 1'b1;
                stall_armed = 1'b0;
                if (expected_outputs.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with none expected",
                                              result.dot_result));
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (result.dot_result !== want.dot_result)
                        report_mismatch($sformatf("dot_result %0d, expected %0d",
                                                  result.dot_result, want.dot_result));
                    if (result.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated %0b, expected %0b",
                                                  result.saturated, want.saturated));
                end
            end
            if (item_valid && item_ready)
            begin
                moved      = 1'b1;
                item_fired = 1'b1;
                accumulate_word(item);
            end

            if (moved)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("[%0t] watchdog: no transaction for %0d cycles",
                             $time, IDLE_LIMIT);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Item driver: presents queued words at the falling edge. Valid is held
    // until the transaction is taken; each word then draws how long the
    // sender rests before the next one, with occasional back-to-back runs.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_fired)
        begin
            item_fired = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: when a new result shows up, it draws a stall and holds
    // ready low for that many cycles before taking it. Ready rests high
    // otherwise, so stall-free stretches come from draws of zero and bursts.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && !stall_armed)
            begin
                stall_armed = 1'b1;
                if ($urandom_range(0, 15) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    // Mix of extremes, values near zero and full-range values.
    function automatic logic signed [15:0] random_q16();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return r[15:0];
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic item_t random_item(logic [1:0] bnd);
        item_t it;
        it.weight_word = random_word();
        it.act_0       = random_q16();
        it.act_1       = random_q16();
        it.act_2       = random_q16();
        it.act_3       = random_q16();
        it.act_4       = random_q16();
        it.act_5       = random_q16();
        it.act_6       = random_q16();
        it.act_7       = random_q16();
        it.group_scale = random_q16();
        it.group_bias  = random_q16();
        it.boundary    = bnd;
        return it;
    endfunction

    // A word whose eight activations are all the same.
    function automatic item_t uniform_item(logic [31:0] word, logic signed [15:0] act,
                                           logic signed [15:0] scale,
                                           logic signed [15:0] bias, logic [1:0] bnd);
        item_t it;
        it.weight_word = word;
        {it.act_0, it.act_1, it.act_2, it.act_3} = {4{act}};
        {it.act_4, it.act_5, it.act_6, it.act_7} = {4{act}};
        it.group_scale = scale;
        it.group_bias  = bias;
        it.boundary    = bnd;
        return it;
    endfunction

    function automatic logic [1:0] word_code(int g, int groups, int w, int len,
                                             logic [1:0] last_code);
        if (w != len - 1)
            return BND_INNER;
        return (g == groups - 1) ? last_code : BND_GROUP_END;
    endfunction

    task automatic queue_item(item_t it);
        pending_items.push_back(it);
        words_queued++;
    endtask

    // One well-formed output of random words, each group random in length.
    task automatic queue_random_output(int groups, int min_len, int max_len,
                                       logic [1:0] last_code);
        int len;
        for (int g = 0; g < groups; g++)
        begin
            len = $urandom_range(min_len, max_len);
            for (int w = 0; w < len; w++)
                queue_item(random_item(word_code(g, groups, w, len, last_code)));
        end
    endtask

    // One output of identical words with full-scale coefficients, used to
    // drive the accumulators into their rails.
    task automatic queue_rail_output(int groups, int len, logic [31:0] word,
                                     logic signed [15:0] act);
        for (int g = 0; g < groups; g++)
            for (int w = 0; w < len; w++)
                queue_item(uniform_item(word, act, Q_MAX, Q_MAX,
                                        word_code(g, groups, w, len, BND_OUTPUT_END)));
    endtask

    // Waits until every queued word has been taken and every result is back.
    task automatic wait_for_drain();
        while (pending_items.size() != 0 || item_valid || expected_outputs.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_t it;
        int    start_count;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Corner words, each a complete output unless noted.
        queue_item(uniform_item(32'h0000_0000, 16'sd0, 16'sd0, 16'sd0, BND_OUTPUT_END));
        queue_item(uniform_item(32'hFFFF_FFFF, Q_MAX, Q_MAX, Q_MAX, BND_OUTPUT_END));
        queue_item(uniform_item(32'hFFFF_FFFF, Q_MIN, Q_MIN, Q_MIN, BND_OUTPUT_END));
        queue_item(uniform_item(32'hFFFF_FFFF, Q_MIN, Q_MAX, Q_MIN, BND_RESERVED));
        // Zero codes leave only the bias term.
        queue_item(uniform_item(32'h0000_0000, Q_MAX, Q_MIN, Q_MAX, BND_OUTPUT_END));
        // Lane order: activation i is i in Q8.8 against code i, unit scale.
        it = uniform_item(32'h7654_3210, 16'sd0, 16'sh1000, 16'sd0, BND_OUTPUT_END);
        {it.act_0, it.act_1, it.act_2, it.act_3} = {16'sd0, 16'sd256, 16'sd512, 16'sd768};
        {it.act_4, it.act_5, it.act_6, it.act_7} = {16'sd1024, 16'sd1280, 16'sd1536,
                                                    16'sd1792};
        queue_item(it);
        // Two groups; the coefficients on inner words must be ignored.
        queue_item(uniform_item(32'h0F0F_0F0F, Q_MAX, Q_MIN, Q_MIN, BND_INNER));
        queue_item(uniform_item(32'hF0F0_F0F0, Q_MIN, 16'sh1000, 16'sh0800,
                                BND_GROUP_END));
        queue_item(uniform_item(32'hA5A5_A5A5, 16'sd1, Q_MAX, Q_MAX, BND_INNER));
        queue_item(uniform_item(32'h5A5A_5A5A, -16'sd1, -16'sd4096, 16'sd1,
                                BND_OUTPUT_END));
        // A group end right before a reserved-code output end.
        queue_item(uniform_item(32'h1234_5678, 16'sh0100, 16'sh1000, 16'sh1000,
                                BND_GROUP_END));
        queue_item(uniform_item(32'h8765_4321, -16'sh0100, 16'sh1000, -16'sh1000,
                                BND_RESERVED));
        queue_item(random_item(BND_INNER));
        queue_item(random_item(BND_GROUP_END));
        queue_item(random_item(BND_OUTPUT_END));

        // Hold the sender off until the core has emptied completely.
        wait_for_drain();

        // Overlong groups: both sums clip high; then only the activation sum
        // clips low.
        queue_rail_output(1, 36, 32'hFFFF_FFFF, Q_MAX);
        queue_rail_output(1, 34, 32'h1111_1111, Q_MIN);

        // Randomly shaped outputs: mostly short groups, now and then a long
        // one, some single-word outputs, some closed by the reserved code.
        start_count = words_queued;
        while (words_queued - start_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: queue_random_output(1, 1, 1, BND_OUTPUT_END);
                1: queue_random_output(1, 20, 40, BND_OUTPUT_END);
                2: queue_random_output($urandom_range(1, 4), 1, 6, BND_RESERVED);
                default: queue_random_output($urandom_range(1, 4), 1, 6, BND_OUTPUT_END);
            endcase
        end

        wait_for_drain();
        // Give a stray result time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
